// ===== hw/rtl/sbavg_pkg.sv =====
// ----------------------------------------------------------------------------
// sbavg_pkg
// Shared sizes, item codes and controller/datapath interface structs for the
// sorted point bin averager.
// ----------------------------------------------------------------------------
`default_nettype none

package sbavg_pkg;

	// Depth of the edge store and width of the per-bin point counter.
	localparam int MAX_EDGES  = 256;
	localparam int COUNT_BITS = 16;

	// Fixed field widths.
	localparam int WORD_W = 32;
	localparam int BIN_W  = 8;
	localparam int MODE_W = 2;

	// Derived sizes.
	localparam int EDGE_AW = (MAX_EDGES > 2) ? $clog2(MAX_EDGES) : 1;
	// Wide enough for an edge store index and for a bin number plus one.
	localparam int IDX_W   = (EDGE_AW + 1 > BIN_W + 1) ? EDGE_AW + 1 : BIN_W + 1;
	// A sum of up to 2^COUNT_BITS-1 words never leaves this width.
	localparam int SUM_W   = WORD_W + COUNT_BITS;
	// Largest usable bin count.
	localparam int NB_MAX  = (MAX_EDGES - 1 > 255) ? 255 : MAX_EDGES - 1;

	// Item codes carried in the mode field.
	localparam logic [MODE_W-1:0] MODE_EDGE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_POINT = 2'd1;
	localparam logic [MODE_W-1:0] MODE_END   = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic cap_point;    // register the accepted item's point fields
		logic wr_edge;      // write the accepted item's edge into the store
		logic rd_en;        // read one edge of the current bin
		logic rd_hi;        // read the upper edge instead of the lower one
		logic lo_ld;        // take the read edge as the lower edge
		logic hi_ld;        // take the read edge as the upper edge
		logic acc;          // accumulate the point, or flag it if the count is full
		logic inc_bin;      // move to the next bin
		logic set_fin;      // mark the data set as finished
		logic rewind;       // restart for a new data set
		logic div_start;    // start one division by the point count
		logic div_sel_err;  // divide the error sum instead of the value sum
		logic avg_v_ld;     // keep the signed value average
		logic out_ld;       // load the output register
		logic clear_acc;    // clear the accumulators after a report
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic set_fin;      // data set is finished
		logic bin_past;     // current bin is not below the bin count
		logic next_past;    // the bin after the current one is not below the count
		logic count_nz;     // the current bin holds points
		logic pos_lt_lo;    // point lies below the lower edge
		logic pos_gt_hi;    // point lies above the upper edge
		logic div_done;     // division finished in this cycle
		logic out_free;     // output register can take a result now
	} stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/sbavg_divider.sv =====
// ----------------------------------------------------------------------------
// sbavg_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sbavg_divider
	import sbavg_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [SUM_W-1:0]      dividend,
	input  wire logic [COUNT_BITS-1:0] divisor,
	output logic                       busy,
	output logic                       done,
	output logic [SUM_W-1:0]           quotient
);

	localparam int CNT_W = $clog2(SUM_W + 1);

	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic [SUM_W-1:0]      quo_q;
	logic [COUNT_BITS-1:0] rem_q;
	logic [COUNT_BITS-1:0] div_q;

	logic [COUNT_BITS:0]   shifted;
	logic [COUNT_BITS:0]   diff;
	logic                  fits;

	assign shifted = {rem_q, quo_q[SUM_W-1]};
	assign fits    = shifted >= {1'b0, div_q};
	assign diff    = shifted - {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(SUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[SUM_W-2:0], fits};
			rem_q <= fits ? diff[COUNT_BITS-1:0] : shifted[COUNT_BITS-1:0];
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/sbavg_datapath.sv =====
// ----------------------------------------------------------------------------
// sbavg_datapath
// Edge store, bin and accumulator registers, divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sbavg_datapath
	import sbavg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	output stat_t                  stat,
	input  wire logic              cfg_we,
	input  wire logic [BIN_W-1:0]  cfg_wdata,
	input  wire logic [BIN_W-1:0]  edge_index,
	input  wire logic [WORD_W-1:0] edge_value,
	input  wire logic [WORD_W-1:0] point_position,
	input  wire logic [WORD_W-1:0] point_value,
	input  wire logic [WORD_W-1:0] point_error,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [BIN_W-1:0]       bin_number,
	output logic [WORD_W-1:0]      bin_center,
	output logic [WORD_W-1:0]      average_value,
	output logic [WORD_W-1:0]      average_error,
	output logic                   count_saturated
);

	localparam logic [COUNT_BITS-1:0] COUNT_LIMIT = '1;

	logic [WORD_W-1:0] edge_mem [MAX_EDGES];

	logic [BIN_W-1:0]      nb_q;
	logic [BIN_W-1:0]      nb_eff;
	logic [BIN_W-1:0]      cur_q;
	logic                  fin_q;
	logic [SUM_W-1:0]      value_sum_q;
	logic [SUM_W-1:0]      error_sum_q;
	logic [COUNT_BITS-1:0] count_q;
	logic                  dropped_q;

	logic [WORD_W-1:0]     pos_q;
	logic [WORD_W-1:0]     val_q;
	logic [WORD_W-1:0]     err_q;
	logic [WORD_W-1:0]     lo_q;
	logic [WORD_W-1:0]     hi_q;
	logic [WORD_W-1:0]     rdata_q;
	logic                  rzero_q;
	logic [WORD_W-1:0]     avg_v_q;
	logic [WORD_W-1:0]     edge_data;

	logic [IDX_W-1:0]      widx;
	logic [IDX_W-1:0]      ridx;
	logic [IDX_W-1:0]      next_bin;

	logic [SUM_W-1:0]      value_mag;
	logic [SUM_W-1:0]      dividend;
	logic                  div_busy;
	logic                  div_done;
	logic [SUM_W-1:0]      quotient;
	logic [WORD_W-1:0]     quo_word;
	logic [WORD_W:0]       edge_sum;

	logic                  out_valid_q;
	logic [BIN_W-1:0]      bin_number_q;
	logic [WORD_W-1:0]     bin_center_q;
	logic [WORD_W-1:0]     average_value_q;
	logic [WORD_W-1:0]     average_error_q;
	logic                  count_saturated_q;

	// A bin count of zero acts as one; counts past the store act as its last bin.
	always_comb begin
		if (nb_q == '0) begin
			nb_eff = BIN_W'(1);
		end else if (nb_q > BIN_W'(NB_MAX)) begin
			nb_eff = BIN_W'(NB_MAX);
		end else begin
			nb_eff = nb_q;
		end
	end

	assign widx     = IDX_W'(edge_index);
	assign ridx     = IDX_W'(cur_q) + (cmd.rd_hi ? IDX_W'(1) : IDX_W'(0));
	assign next_bin = IDX_W'(cur_q) + IDX_W'(1);

	// Edge store: one write port at item accept, one registered read port.
	always_ff @(posedge clk) begin
		if (cmd.wr_edge && (widx < IDX_W'(MAX_EDGES))) begin
			edge_mem[widx[EDGE_AW-1:0]] <= edge_value;
		end
		if (cmd.rd_en) begin
			rdata_q <= edge_mem[ridx[EDGE_AW-1:0]];
			rzero_q <= !(ridx < IDX_W'(MAX_EDGES));
		end
	end

	// Edges past the end of the store read as zero.
	assign edge_data = rzero_q ? '0 : rdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nb_q        <= BIN_W'(1);
			cur_q       <= '0;
			fin_q       <= 1'b0;
			value_sum_q <= '0;
			error_sum_q <= '0;
			count_q     <= '0;
			dropped_q   <= 1'b0;
		end else begin
			if (cfg_we) begin
				nb_q <= cfg_wdata;
			end
			if (cmd.rewind) begin
				cur_q       <= '0;
				fin_q       <= 1'b0;
				value_sum_q <= '0;
				error_sum_q <= '0;
				count_q     <= '0;
				dropped_q   <= 1'b0;
			end else begin
				if (cmd.inc_bin) begin
					cur_q <= cur_q + 1'b1;
				end
				if (cmd.set_fin) begin
					fin_q <= 1'b1;
				end
				if (cmd.clear_acc) begin
					value_sum_q <= '0;
					error_sum_q <= '0;
					count_q     <= '0;
					dropped_q   <= 1'b0;
				end else if (cmd.acc) begin
					if (count_q == COUNT_LIMIT) begin
						dropped_q <= 1'b1;
					end else begin
						value_sum_q <= value_sum_q
							+ {{(SUM_W - WORD_W){val_q[WORD_W-1]}}, val_q};
						error_sum_q <= error_sum_q + SUM_W'(err_q);
						count_q     <= count_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap_point) begin
			pos_q <= point_position;
			val_q <= point_value;
			err_q <= point_error;
		end
		if (cmd.lo_ld) begin
			lo_q <= edge_data;
		end
		if (cmd.hi_ld) begin
			hi_q <= edge_data;
		end
		if (cmd.avg_v_ld) begin
			avg_v_q <= value_sum_q[SUM_W-1] ? (~quo_word + 1'b1) : quo_word;
		end
	end

	// The value sum is divided as a magnitude and the sign is put back after.
	assign value_mag = value_sum_q[SUM_W-1] ? (~value_sum_q + 1'b1) : value_sum_q;
	assign dividend  = cmd.div_sel_err ? error_sum_q : value_mag;
	assign quo_word  = quotient[WORD_W-1:0];

	sbavg_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (dividend),
		.divisor  (count_q),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quotient)
	);

	assign edge_sum = {1'b0, lo_q} + {1'b0, hi_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_ld) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			bin_number_q      <= cur_q;
			bin_center_q      <= edge_sum[WORD_W:1];
			average_value_q   <= avg_v_q;
			average_error_q   <= quo_word;
			count_saturated_q <= dropped_q;
		end
	end

	assign stat.set_fin   = fin_q;
	assign stat.bin_past  = !(cur_q < nb_eff);
	assign stat.next_past = !(next_bin < IDX_W'(nb_eff));
	assign stat.count_nz  = count_q != '0;
	assign stat.pos_lt_lo = pos_q < lo_q;
	assign stat.pos_gt_hi = pos_q > hi_q;
	assign stat.div_done  = div_done;
	assign stat.out_free  = !out_valid_q || out_ready;

	assign out_valid       = out_valid_q;
	assign bin_number      = bin_number_q;
	assign bin_center      = bin_center_q;
	assign average_value   = average_value_q;
	assign average_error   = average_error_q;
	assign count_saturated = count_saturated_q;

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> (!out_valid_q || out_ready))
		else $error("result loaded over one that was not taken");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy)
		else $error("division started while one is running");

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> (count_q != '0))
		else $error("division by an empty count");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(dropped_q) |-> (count_q == COUNT_LIMIT))
		else $error("point dropped while the count was not full");

endmodule

`default_nettype wire

// ===== hw/rtl/sbavg_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbavg_ctrl
// Controller: item decode, bin walk and report sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module sbavg_ctrl
	import sbavg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [MODE_W-1:0] mode,
	input  wire stat_t             stat,
	output cmd_t                   cmd
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_RD_LO,
		S_RD_HI,
		S_RD_END,
		S_CMP,
		S_ADV,
		S_DIV_V,
		S_DIV_V_W,
		S_DIV_E,
		S_DIV_E_W,
		S_EMIT
	} state_t;

	// What follows a report.
	typedef enum logic [1:0] {
		RET_ADV,
		RET_FINISH,
		RET_REWIND
	} ret_t;

	state_t state_q, state_d;
	ret_t   ret_q, ret_d;
	logic   first_q, first_d;
	logic   report_q, report_d;
	logic   accept;

	assign in_ready = state_q == S_IDLE;
	assign accept   = in_valid && in_ready;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		ret_d    = ret_q;
		first_d  = first_q;
		report_d = report_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.cap_point = 1'b1;
					unique case (mode)
						MODE_EDGE: begin
							cmd.wr_edge = 1'b1;
						end
						MODE_POINT: begin
							if (!stat.set_fin) begin
								if (stat.bin_past) begin
									// The bin count shrank under the current bin.
									if (stat.count_nz) begin
										report_d = 1'b1;
										ret_d    = RET_FINISH;
										state_d  = S_RD_LO;
									end else begin
										cmd.set_fin = 1'b1;
									end
								end else begin
									report_d = 1'b0;
									first_d  = 1'b1;
									state_d  = S_RD_LO;
								end
							end
						end
						MODE_END: begin
							if (!stat.set_fin && stat.count_nz) begin
								report_d = 1'b1;
								ret_d    = RET_REWIND;
								state_d  = S_RD_LO;
							end else begin
								cmd.rewind = 1'b1;
							end
						end
						default: begin
						end
					endcase
				end
			end
			S_RD_LO: begin
				cmd.rd_en = 1'b1;
				state_d   = S_RD_HI;
			end
			S_RD_HI: begin
				cmd.lo_ld = 1'b1;
				cmd.rd_en = 1'b1;
				cmd.rd_hi = 1'b1;
				state_d   = S_RD_END;
			end
			S_RD_END: begin
				cmd.hi_ld = 1'b1;
				state_d   = report_q ? S_DIV_V : S_CMP;
			end
			S_CMP: begin
				// The first look at a point tests the lower edge first; after an
				// advance the upper edge comes first.
				priority if (first_q && stat.pos_lt_lo) begin
					state_d = S_IDLE;
				end else if (stat.pos_gt_hi) begin
					if (stat.count_nz) begin
						ret_d   = RET_ADV;
						state_d = S_DIV_V;
					end else begin
						state_d = S_ADV;
					end
				end else if (stat.pos_lt_lo) begin
					state_d = S_IDLE;
				end else begin
					cmd.acc = 1'b1;
					state_d = S_IDLE;
				end
			end
			S_ADV: begin
				cmd.inc_bin = 1'b1;
				if (stat.next_past) begin
					cmd.set_fin = 1'b1;
					state_d     = S_IDLE;
				end else begin
					first_d  = 1'b0;
					report_d = 1'b0;
					state_d  = S_RD_LO;
				end
			end
			S_DIV_V: begin
				cmd.div_start = 1'b1;
				state_d       = S_DIV_V_W;
			end
			S_DIV_V_W: begin
				if (stat.div_done) begin
					cmd.avg_v_ld = 1'b1;
					state_d      = S_DIV_E;
				end
			end
			S_DIV_E: begin
				cmd.div_start   = 1'b1;
				cmd.div_sel_err = 1'b1;
				state_d         = S_DIV_E_W;
			end
			S_DIV_E_W: begin
				if (stat.div_done) begin
					state_d = S_EMIT;
				end
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.out_ld    = 1'b1;
					cmd.clear_acc = 1'b1;
					unique case (ret_q)
						RET_ADV: begin
							state_d = S_ADV;
						end
						RET_FINISH: begin
							cmd.set_fin = 1'b1;
							state_d     = S_IDLE;
						end
						RET_REWIND: begin
							cmd.rewind = 1'b1;
							state_d    = S_IDLE;
						end
						default: begin
							state_d = S_IDLE;
						end
					endcase
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			ret_q    <= RET_ADV;
			first_q  <= 1'b0;
			report_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			ret_q    <= ret_d;
			first_q  <= first_d;
			report_q <= report_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/sorted_point_bin_averager.sv =====
// ----------------------------------------------------------------------------
// sorted_point_bin_averager
// Averages a position-sorted stream of points into bins with loaded edges.
// ----------------------------------------------------------------------------
// Usage: the input channel (in_valid/in_ready) carries one item per handshake.
// An edge item (mode 0) writes one bin edge. A point item (mode 1) is
// compared with the current bin unless the set is finished: it lands in the
// bin or is skipped, and the block walks on past each empty bin below it.
// An end item (mode 2) reports the current bin if it holds points and
// rewinds for a new set. Leaving a bin that holds points produces one result
// item on the output channel (out_valid/out_ready). A report runs two
// divisions by the point count on one shared radix-2 divider; one item is
// worked on at a time. The result sits in an output register, so the next
// item is accepted while a result waits; a second report waits only until
// that register is taken. The bin count register (cfg_we/cfg_wdata) must be
// written only while the block idles; the block itself does not enforce it.
// Reset clears the bin, the accumulators and the finished flag and sets the
// bin count to one; the edge store keeps no reset value and must be loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_point_bin_averager
	import sbavg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [BIN_W-1:0]  cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [MODE_W-1:0] mode,
	input  wire logic [BIN_W-1:0]  edge_index,
	input  wire logic [WORD_W-1:0] edge_value,
	input  wire logic [WORD_W-1:0] point_position,
	input  wire logic [WORD_W-1:0] point_value,
	input  wire logic [WORD_W-1:0] point_error,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [BIN_W-1:0]       bin_number,
	output logic [WORD_W-1:0]      bin_center,
	output logic [WORD_W-1:0]      average_value,
	output logic [WORD_W-1:0]      average_error,
	output logic                   count_saturated
);

	// Commands flow from the controller, status flows back from the datapath.
	cmd_t  cmd;
	stat_t stat;

	// The controller decodes items, walks bins and sequences each report.
	sbavg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.mode     (mode),
		.stat     (stat),
		.cmd      (cmd)
	);

	// The datapath holds the edge store, accumulators, divider and output.
	sbavg_datapath u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.edge_index      (edge_index),
		.edge_value      (edge_value),
		.point_position  (point_position),
		.point_value     (point_value),
		.point_error     (point_error),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.bin_number      (bin_number),
		.bin_center      (bin_center),
		.average_value   (average_value),
		.average_error   (average_error),
		.count_saturated (count_saturated)
	);

endmodule

`default_nettype wire
